[sv/sbb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbb_pkg
// Shared types and constants of the separable box blur.
// ----------------------------------------------------------------------------
package sbb_pkg;

	localparam int MAX_RADIUS_DEF = 15;
	localparam int MAX_WIDTH_DEF  = 1024;

	localparam int COORD_W = 11;
	localparam int CHAN_W  = 8;
	localparam int PIX_W   = 3 * CHAN_W;
	localparam int POS_W   = 23;

	localparam logic [1:0] CFG_RADIUS = 2'd0;
	localparam logic [1:0] CFG_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_HEIGHT = 2'd2;

	localparam logic [3:0]         RADIUS_RST = 4'd1;
	localparam logic [COORD_W-1:0] WIDTH_RST  = 11'd1024;
	localparam logic [COORD_W-1:0] HEIGHT_RST = 11'd1024;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DSTART,
		ST_DIV,
		ST_PUSH
	} state_t;

endpackage

[sv/separable_box_blur.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// separable_box_blur
// Streaming box blur over a square window, with the recent rows of the frame
// held in one line store RAM that is read back for each output pixel.
// ----------------------------------------------------------------------------
// Items that give no result leave the block idle. An item that gives a result
// holds the input until its result is loaded into the output registers: N
// window pixels (up to (2r+1)^2) read one per cycle, then the divider over the
// S-bit sums, with S the sum width (18 at the defaults), plus any output stall.
// Reset clears control, positions and output valid and sets radius 1, width
// 1024, height 1024. The line store is not cleared.
module separable_box_blur #(
	parameter int MAX_RADIUS = sbb_pkg::MAX_RADIUS_DEF,
	parameter int MAX_WIDTH  = sbb_pkg::MAX_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [sbb_pkg::CHAN_W-1:0]  red_in,
	input  logic [sbb_pkg::CHAN_W-1:0]  green_in,
	input  logic [sbb_pkg::CHAN_W-1:0]  blue_in,
	input  logic                        is_flush,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [sbb_pkg::CHAN_W-1:0]  red_out,
	output logic [sbb_pkg::CHAN_W-1:0]  green_out,
	output logic [sbb_pkg::CHAN_W-1:0]  blue_out,
	output logic                        last_in_frame,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [sbb_pkg::COORD_W-1:0] cfg_data
);

	localparam int SR     = 2 * MAX_RADIUS + 2;
	localparam int WIN    = 2 * MAX_RADIUS + 1;
	localparam int DEPTH  = SR * MAX_WIDTH;
	localparam int AW     = $clog2(DEPTH);
	localparam int SLOT_W = $clog2(SR);
	localparam int RW     = $clog2(MAX_RADIUS + 1);
	localparam int SUM_W  = $clog2(WIN * WIN * 255 + 1);
	localparam int DIV_W  = $clog2(WIN * WIN + 1);
	localparam int CW     = sbb_pkg::COORD_W;
	localparam int PW     = sbb_pkg::POS_W;

	sbb_pkg::state_t state_q, state_d;

	logic [3:0]    radius_q;
	logic [CW-1:0] image_width_q, image_height_q;

	logic [RW-1:0]  er;
	logic [CW-1:0]  ew, eh;
	logic [PW-1:0]  total, delay;

	logic [PW-1:0]     ip_q, op_q;
	logic [CW-1:0]     ix_q, ox_q, oy_q;
	logic [SLOT_W-1:0] islot_q, oslot_q;

	logic [CW-1:0]     xlo_q, xhi_q, yhi_q, cx_q, cy_q;
	logic [SLOT_W-1:0] cslot_q;
	logic              rd_s1;
	logic              scan_last;

	logic [2:0][SUM_W-1:0]          sum_q;
	logic [2:0][sbb_pkg::CHAN_W-1:0] quo;
	logic                            div_done;
	logic [DIV_W-1:0]                divisor;

	logic                    accept, out_take, load_out;
	logic                    we;
	logic [AW-1:0]           waddr, raddr;
	logic [sbb_pkg::PIX_W-1:0] wdata, rdata;
	logic                    out_valid_q;

	// Effective configuration.
	always_comb begin
		logic [RW:0] d1;
		if (32'(radius_q) > MAX_RADIUS) er = RW'(MAX_RADIUS);
		else er = RW'(radius_q);
		if (image_width_q == '0) ew = CW'(1);
		else if (32'(image_width_q) > MAX_WIDTH) ew = CW'(MAX_WIDTH);
		else ew = image_width_q;
		eh = (image_height_q == '0) ? CW'(1) : image_height_q;
		total = PW'(32'(ew) * 32'(eh));
		delay = PW'(32'(er) * 32'(ew) + 32'(er));
		d1 = {er, 1'b1};
		divisor = DIV_W'(32'(d1) * 32'(d1));
	end

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != sbb_pkg::ST_IDLE);
	assign out_take  = out_valid_q && !out_stall;
	assign load_out  = (state_q == sbb_pkg::ST_PUSH) && (!out_valid_q || !out_stall);
	assign scan_last = (cx_q == xhi_q) && (cy_q == yhi_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			sbb_pkg::ST_IDLE: begin
				if (accept && ip_q >= delay) state_d = sbb_pkg::ST_SCAN;
			end
			sbb_pkg::ST_SCAN: begin
				if (scan_last) state_d = sbb_pkg::ST_DRAIN;
			end
			sbb_pkg::ST_DRAIN:  state_d = sbb_pkg::ST_DSTART;
			sbb_pkg::ST_DSTART: state_d = sbb_pkg::ST_DIV;
			sbb_pkg::ST_DIV: begin
				if (div_done) state_d = sbb_pkg::ST_PUSH;
			end
			sbb_pkg::ST_PUSH: begin
				if (load_out) state_d = sbb_pkg::ST_IDLE;
			end
			default: state_d = sbb_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= sbb_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// Configuration, positions, output valid and last-in-frame flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q       <= sbb_pkg::RADIUS_RST;
			image_width_q  <= sbb_pkg::WIDTH_RST;
			image_height_q <= sbb_pkg::HEIGHT_RST;
			ip_q <= '0; ix_q <= '0; islot_q <= '0;
			op_q <= '0; ox_q <= '0; oy_q <= '0; oslot_q <= '0;
			out_valid_q <= 1'b0;
			last_in_frame <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					sbb_pkg::CFG_RADIUS: radius_q <= cfg_data[3:0];
					sbb_pkg::CFG_WIDTH:  image_width_q <= cfg_data;
					sbb_pkg::CFG_HEIGHT: image_height_q <= cfg_data;
					default: ;
				endcase
				ip_q <= '0; ix_q <= '0; islot_q <= '0;
				op_q <= '0; ox_q <= '0; oy_q <= '0; oslot_q <= '0;
			end else if (accept) begin
				ip_q <= ip_q + 1'b1;
				if (ip_q < total) begin
					if (ix_q == ew - 1'b1) begin
						ix_q <= '0;
						islot_q <= (32'(islot_q) == SR - 1) ? '0 : islot_q + 1'b1;
					end else begin
						ix_q <= ix_q + 1'b1;
					end
				end
			end else if (load_out) begin
				if (op_q + 1'b1 >= total) begin
					ip_q <= '0; ix_q <= '0; islot_q <= '0;
					op_q <= '0; ox_q <= '0; oy_q <= '0; oslot_q <= '0;
				end else begin
					op_q <= op_q + 1'b1;
					if (ox_q == ew - 1'b1) begin
						ox_q <= '0;
						oy_q <= oy_q + 1'b1;
						oslot_q <= (32'(oslot_q) == SR - 1) ? '0 : oslot_q + 1'b1;
					end else begin
						ox_q <= ox_q + 1'b1;
					end
				end
			end
			if (load_out) begin
				out_valid_q   <= 1'b1;
				last_in_frame <= (op_q + 1'b1 >= total);
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			red_out   <= quo[0];
			green_out <= quo[1];
			blue_out  <= quo[2];
		end
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= (state_q == sbb_pkg::ST_SCAN);
		end
	end

	// Window bounds, clipped to the frame, and the scan over them.
	always_ff @(posedge clk) begin
		logic [CW:0] r12, lo, hi, back, sl;
		r12 = (CW+1)'(er);
		if (state_q == sbb_pkg::ST_IDLE) begin
			lo = ({1'b0, oy_q} >= r12) ? {1'b0, oy_q} - r12 : '0;
			hi = {1'b0, oy_q} + r12;
			yhi_q <= (hi > {1'b0, eh} - 1'b1) ? eh - 1'b1 : hi[CW-1:0];
			cy_q  <= lo[CW-1:0];
			back  = {1'b0, oy_q} - lo;
			sl    = (CW+1)'(oslot_q);
			cslot_q <= (sl >= back) ? SLOT_W'(sl - back) : SLOT_W'(sl + (CW+1)'(SR) - back);
			lo = ({1'b0, ox_q} >= r12) ? {1'b0, ox_q} - r12 : '0;
			hi = {1'b0, ox_q} + r12;
			xlo_q <= lo[CW-1:0];
			cx_q  <= lo[CW-1:0];
			xhi_q <= (hi > {1'b0, ew} - 1'b1) ? ew - 1'b1 : hi[CW-1:0];
		end else if (state_q == sbb_pkg::ST_SCAN) begin
			if (cx_q == xhi_q) begin
				cx_q <= xlo_q;
				cy_q <= cy_q + 1'b1;
				cslot_q <= (32'(cslot_q) == SR - 1) ? '0 : cslot_q + 1'b1;
			end else begin
				cx_q <= cx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sbb_pkg::ST_IDLE) begin
			sum_q <= '0;
		end else if (rd_s1) begin
			for (int c = 0; c < 3; c++) begin
				sum_q[c] <= sum_q[c] + SUM_W'(rdata[c*sbb_pkg::CHAN_W +: sbb_pkg::CHAN_W]);
			end
		end
	end

	assign we    = accept && (ip_q < total);
	assign wdata = is_flush ? '0 : {blue_in, green_in, red_in};
	assign waddr = AW'(32'(islot_q) * MAX_WIDTH + 32'(ix_q));
	assign raddr = AW'(32'(cslot_q) * MAX_WIDTH + 32'(cx_q));

	sbb_ram #(
		.WIDTH(sbb_pkg::PIX_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	sbb_div #(
		.SUM_W(SUM_W),
		.DIV_W(DIV_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == sbb_pkg::ST_DSTART),
		.dividend(sum_q),
		.divisor (divisor),
		.quotient(quo),
		.done    (div_done)
	);

endmodule

[sv/sbb_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbb_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sbb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/sbb_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbb_div
// Restoring divider, one quotient bit per cycle, three channels sharing
// one divisor.
// ----------------------------------------------------------------------------
module sbb_div #(
	parameter int SUM_W = 18,
	parameter int DIV_W = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [2:0][SUM_W-1:0]       dividend,
	input  logic [DIV_W-1:0]            divisor,
	output logic [2:0][sbb_pkg::CHAN_W-1:0] quotient,
	output logic                        done
);

	localparam int CNT_W = $clog2(SUM_W);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIV_W-1:0]      d_q;
	logic [2:0][SUM_W-1:0] q_q;
	logic [2:0][DIV_W-1:0] rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [DIV_W:0] sh;
		if (start) begin
			d_q <= divisor;
			for (int c = 0; c < 3; c++) begin
				q_q[c]   <= dividend[c];
				rem_q[c] <= '0;
			end
		end else if (busy_q) begin
			for (int c = 0; c < 3; c++) begin
				sh = {rem_q[c], q_q[c][SUM_W-1]};
				if (sh >= {1'b0, d_q}) begin
					rem_q[c] <= DIV_W'(sh - {1'b0, d_q});
					q_q[c]   <= {q_q[c][SUM_W-2:0], 1'b1};
				end else begin
					rem_q[c] <= sh[DIV_W-1:0];
					q_q[c]   <= {q_q[c][SUM_W-2:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			quotient[c] = q_q[c][sbb_pkg::CHAN_W-1:0];
		end
	end

	assign done = done_q;

endmodule
